// ===== rtl/rlde_pkg.sv =====
// Shared types and constants for the run-length decimal encoder.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package rlde_pkg;

    // Counter width of a run and the decimal cap that keeps a run to six bytes.
    localparam int RUN_COUNT_BITS = 16;
    localparam longint DIGIT_CAP = 64'd99999;

    function automatic longint count_limit_f();
        longint lim;
        int bits;
        bits = (RUN_COUNT_BITS > 32) ? 32 : RUN_COUNT_BITS;
        lim = (longint'(1) << bits) - 1;
        if (lim > DIGIT_CAP) lim = DIGIT_CAP;
        if (lim < 1) lim = 1;
        return lim;
    endfunction

    function automatic int digit_count_f(longint v);
        int n;
        longint p;
        n = 1;
        p = 10;
        while (p <= v) begin
            n = n + 1;
            p = p * 10;
        end
        return n;
    endfunction

    localparam longint RUN_LIMIT  = count_limit_f();
    localparam int     LEN_W      = $clog2(RUN_LIMIT + 1);
    localparam int     NUM_DIGITS = digit_count_f(RUN_LIMIT);
    localparam int     PLACE_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int     CMP_W      = LEN_W + 4;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Run queue between the front and back halves; depth is a power of two.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    function automatic int pow10_f(int k);
        int p;
        p = 1;
        for (int i = 0; i < k; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    function automatic int mult10_f(int m, int k);
        return m * pow10_f(k);
    endfunction

    // One closed run, waiting to be spelled out.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [7:0]       sym;
        logic             last;
    } cmd_t;

    // Up to two closed runs per accepted word: the previous run and the final run.
    typedef struct packed {
        logic push_a;
        cmd_t cmd_a;
        logic push_b;
        cmd_t cmd_b;
    } push_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIGIT,
        BK_BYTE
    } back_state_t;

endpackage

// ===== rtl/rlde_front.sv =====
// Front half: accepts input words, tracks the open run and closes runs.
// Depends on rlde_pkg.
`timescale 1ns / 1ps

module rlde_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_symbol,
    input  logic           s_end_of_string,
    input  logic           room,
    output rlde_pkg::push_t push
);

    logic [7:0]                 run_byte_reg, run_byte_next;
    logic [rlde_pkg::LEN_W-1:0] run_length_reg, run_length_next;
    logic                       run_open_reg, run_open_next;

    logic                       accept;
    logic                       same_run;
    logic                       close_prev;
    logic [rlde_pkg::LEN_W-1:0] new_len;

    assign s_ready = room;
    assign accept  = s_valid & room;

    assign same_run = run_open_reg && (s_symbol == run_byte_reg) &&
                      (run_length_reg < rlde_pkg::LEN_W'(rlde_pkg::RUN_LIMIT));
    assign close_prev = run_open_reg && !same_run;
    assign new_len = same_run ? (run_length_reg + rlde_pkg::LEN_W'(1))
                              : rlde_pkg::LEN_W'(1);

    always_comb begin
        push.push_a     = accept && close_prev;
        push.cmd_a.len  = run_length_reg;
        push.cmd_a.sym  = run_byte_reg;
        push.cmd_a.last = 1'b0;
        push.push_b     = accept && s_end_of_string;
        push.cmd_b.len  = new_len;
        push.cmd_b.sym  = s_symbol;
        push.cmd_b.last = 1'b1;
    end

    always_comb begin
        run_byte_next   = run_byte_reg;
        run_length_next = run_length_reg;
        run_open_next   = run_open_reg;
        if (accept) begin
            if (s_end_of_string) begin
                // The string is finished, so nothing stays pending.
                run_byte_next   = 8'd0;
                run_length_next = '0;
                run_open_next   = 1'b0;
            end else begin
                run_byte_next   = s_symbol;
                run_length_next = new_len;
                run_open_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_byte_reg   <= 8'd0;
            run_length_reg <= '0;
            run_open_reg   <= 1'b0;
        end else begin
            run_byte_reg   <= run_byte_next;
            run_length_reg <= run_length_next;
            run_open_reg   <= run_open_next;
        end
    end

endmodule

// ===== rtl/rlde_queue.sv =====
// Short queue of closed runs between the front and back halves.
// Takes up to two runs per cycle, gives one. Depends on rlde_pkg.
`timescale 1ns / 1ps

module rlde_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rlde_pkg::push_t             push,
    output logic                        room,
    output logic                        q_valid,
    output rlde_pkg::cmd_t              q_head,
    input  logic                        q_pop,
    output logic [rlde_pkg::QCNT_W-1:0] q_count
);

    rlde_pkg::cmd_t              mem [rlde_pkg::QDEPTH];
    logic [rlde_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rlde_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rlde_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [rlde_pkg::QPTR_W-1:0] wr_ptr_b;

    // The front only takes a word when both possible runs fit.
    assign room    = count_reg <= rlde_pkg::QCNT_W'(rlde_pkg::QDEPTH - 2);
    assign q_valid = count_reg != '0;
    assign q_head  = mem[rd_ptr_reg];
    assign q_count = count_reg;

    assign wr_ptr_b = wr_ptr_reg + rlde_pkg::QPTR_W'(push.push_a);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + rlde_pkg::QPTR_W'(push.push_a)
                                 + rlde_pkg::QPTR_W'(push.push_b);
        rd_ptr_next = rd_ptr_reg + rlde_pkg::QPTR_W'(q_pop);
        count_next  = count_reg + rlde_pkg::QCNT_W'(push.push_a)
                                + rlde_pkg::QCNT_W'(push.push_b)
                                - rlde_pkg::QCNT_W'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (push.push_a) begin
            mem[wr_ptr_reg] <= push.cmd_a;
        end
        if (push.push_b) begin
            mem[wr_ptr_b] <= push.cmd_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/rlde_back.sv =====
// Back half: spells each closed run as decimal digits, then the run byte, one
// word per cycle unless stalled, to a registered output stage. Depends on rlde_pkg.
`timescale 1ns / 1ps

module rlde_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  rlde_pkg::cmd_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_out_last,
    output logic           idle
);

    rlde_pkg::back_state_t        state_reg, state_next;
    logic [rlde_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic [rlde_pkg::PLACE_W-1:0] place_reg, place_next;
    logic [7:0]                   sym_reg, sym_next;
    logic                         last_reg, last_next;
    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   m_byte_reg, m_byte_next;
    logic                         m_last_reg, m_last_next;

    logic                         adv;
    logic                         load;
    logic                         out_load;
    logic [3:0]                   digit;
    logic [rlde_pkg::CMP_W-1:0]   sub_val;
    logic [rlde_pkg::PLACE_W-1:0] start_place;

    assign adv        = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;
    assign idle       = state_reg == rlde_pkg::BK_IDLE;

    // Current digit: the largest multiple of the place value that fits.
    always_comb begin
        digit   = 4'd0;
        sub_val = '0;
        for (int k = 0; k < rlde_pkg::NUM_DIGITS; k++) begin
            for (int m = 1; m <= 9; m++) begin
                if (place_reg == rlde_pkg::PLACE_W'(k) &&
                    {4'd0, rem_reg} >= rlde_pkg::CMP_W'(rlde_pkg::mult10_f(m, k))) begin
                    digit   = 4'(m);
                    sub_val = rlde_pkg::CMP_W'(rlde_pkg::mult10_f(m, k));
                end
            end
        end
    end

    // Highest nonzero place of a new run length, so no leading zeros appear.
    always_comb begin
        start_place = '0;
        for (int k = 1; k < rlde_pkg::NUM_DIGITS; k++) begin
            if ({4'd0, q_head.len} >= rlde_pkg::CMP_W'(rlde_pkg::pow10_f(k))) begin
                start_place = rlde_pkg::PLACE_W'(k);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rlde_pkg::BK_IDLE: begin
                if (q_valid) state_next = rlde_pkg::BK_DIGIT;
            end
            rlde_pkg::BK_DIGIT: begin
                if (adv && place_reg == '0) state_next = rlde_pkg::BK_BYTE;
            end
            rlde_pkg::BK_BYTE: begin
                if (adv) state_next = q_valid ? rlde_pkg::BK_DIGIT : rlde_pkg::BK_IDLE;
            end
            default: state_next = rlde_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        load        = 1'b0;
        out_load    = 1'b0;
        m_byte_next = m_byte_reg;
        m_last_next = m_last_reg;
        unique case (state_reg)
            rlde_pkg::BK_IDLE: begin
                load = q_valid;
            end
            rlde_pkg::BK_DIGIT: begin
                out_load    = adv;
                m_byte_next = rlde_pkg::ASCII_ZERO + {4'd0, digit};
                m_last_next = 1'b0;
            end
            rlde_pkg::BK_BYTE: begin
                load        = adv && q_valid;
                out_load    = adv;
                m_byte_next = sym_reg;
                m_last_next = last_reg;
            end
            default: begin
                load = 1'b0;
            end
        endcase

        q_pop = load;

        rem_next   = rem_reg;
        place_next = place_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        if (load) begin
            rem_next   = q_head.len;
            place_next = start_place;
            sym_next   = q_head.sym;
            last_next  = q_head.last;
        end else if (state_reg == rlde_pkg::BK_DIGIT && adv) begin
            rem_next = rem_reg - rlde_pkg::LEN_W'(sub_val);
            if (place_reg != '0) place_next = place_reg - rlde_pkg::PLACE_W'(1);
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        place_reg <= place_next;
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        if (out_load) begin
            m_byte_reg <= m_byte_next;
            m_last_reg <= m_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rlde_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/run_length_decimal_encoder.sv =====
// Look-and-say run-length encoder, top level.
// Input channel s_*: one byte per word, s_end_of_string on the last byte of a string.
// Output channel m_*: the encoded string, one byte per word; each run is its
// length in decimal ASCII (no leading zeros) followed by the run byte, and
// m_out_last marks the run byte that ends the encoded string.
// Runs longer than the counter limit are closed at the limit and restarted.
// The front tracks the open run and takes one word per cycle while the run
// queue has room for two closed runs. The back spells out one output word per
// cycle while the receiver accepts, plus a load step whenever it restarts from
// an empty queue; a run of n decimal digits gives n + 1 output words, so the
// back's output port sets the sustained rate. A closed run passes through the run
// queue, the back's run registers and the output register. A stalled receiver
// backs up the queue, and s_ready drops when fewer than two queue slots are free.
// Reset (aresetn low, synchronous) drops any open run, empties the queue and
// clears m_valid. Depends on rlde_pkg, rlde_front, rlde_queue and rlde_back.
`timescale 1ns / 1ps

module run_length_decimal_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_symbol,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    rlde_pkg::push_t             push;
    rlde_pkg::cmd_t              q_head;
    logic                        room;
    logic                        q_valid;
    logic                        q_pop;
    logic [rlde_pkg::QCNT_W-1:0] q_count;
    logic                        back_idle;

    rlde_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_symbol        (s_symbol),
        .s_end_of_string (s_end_of_string),
        .room            (room),
        .push            (push)
    );

    rlde_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .q_count (q_count)
    );

    rlde_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last),
        .idle       (back_idle)
    );

    // The run queue never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= rlde_pkg::QCNT_W'(rlde_pkg::QDEPTH))
        else $error("run queue overflow");

    // Nothing is popped from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty run queue");

    // With no queued run and an idle back half, no output word can appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == '0 && back_idle && !m_valid) |=> !m_valid)
        else $error("output word without a queued run");

    // Reset clears the output stage.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

endmodule
